[rtl/lbb_pkg.sv]
// shared constants, types and sizing helpers for the line box blur
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

    localparam int CHAN_W     = 8;   // bits per pixel component
    localparam int NUM_COMP   = 4;   // components carried on the bus
    localparam int LINE_W     = 13;  // width of the line length register
    localparam int RADIUS_W   = 4;
    localparam int CHCNT_W    = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 2;

    localparam int DEF_MAX_RADIUS = 15;
    localparam int DEF_MAX_LINE   = 4096;
    localparam int DEF_CHANNELS   = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_LENGTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // register values after reset
    localparam logic [RADIUS_W-1:0] RST_RADIUS        = 4'd1;
    localparam logic [LINE_W-1:0]   RST_LINE_LENGTH   = 13'd640;
    localparam logic [CHCNT_W-1:0]  RST_CHANNEL_COUNT = 3'd3;

    // commands from the sequencer to every lane
    typedef struct packed {
        logic wr;         // write incoming component into the window store
        logic clear;      // zero the running sum (line restart)
        logic update;     // apply drop / add to the running sum
        logic add_pix;    // add the captured component
        logic drop;       // subtract the oldest component
        logic div_start;  // load the divider with the new sum
        logic div_step;   // one quotient bit
        logic cnt_zero;   // window is empty, result reads zero
    } lane_ctl_t;

    function automatic int store_depth(input int max_radius);
        return 2 * max_radius + 1;
    endfunction

    function automatic int sum_width(input int max_radius);
        return $clog2((2 * max_radius + 1) * ((1 << CHAN_W) - 1) + 1);
    endfunction

endpackage

`default_nettype wire

[rtl/lbb_lane.sv]
// one component lane: window store slice, running sum and bit-serial divider
// depends on lbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbb_lane #(
    parameter int MAX_RADIUS = lbb_pkg::DEF_MAX_RADIUS
) (
    input  wire                                                 aclk,
    input  wire                                                 aresetn,
    input  lbb_pkg::lane_ctl_t                                  ctl,
    input  wire                                                 active,
    input  wire  [$clog2(lbb_pkg::store_depth(MAX_RADIUS))-1:0] wr_addr,
    input  wire  [$clog2(lbb_pkg::store_depth(MAX_RADIUS))-1:0] rd_addr,
    input  wire  [$clog2(lbb_pkg::store_depth(MAX_RADIUS)+1)-1:0] divisor,
    input  wire  [lbb_pkg::CHAN_W-1:0]                          pix_in,
    output logic [lbb_pkg::CHAN_W-1:0]                          result
);

    localparam int DEPTH = lbb_pkg::store_depth(MAX_RADIUS);
    localparam int SW    = lbb_pkg::sum_width(MAX_RADIUS);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = lbb_pkg::CHAN_W;

    logic [PW-1:0] mem [DEPTH];
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] pix_reg;

    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [SW-1:0] sum_new;
    logic [SW-1:0] sub_val;
    logic [SW-1:0] add_val;
    logic [SW-1:0] left_val;

    logic [SW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [CW:0]   trial;
    logic          fits;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[wr_addr] <= pix_in;
            pix_reg      <= pix_in;
        end
        rd_reg <= mem[rd_addr];
    end

    // saturating drop, then add
    always_comb begin
        sub_val  = ctl.drop ? SW'(rd_reg) : '0;
        add_val  = ctl.add_pix ? SW'(pix_reg) : '0;
        left_val = (sum_reg >= sub_val) ? (sum_reg - sub_val) : '0;
        sum_next = left_val + add_val;
        sum_new  = (ctl.update && active) ? sum_next : sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.clear) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_new;
        end
    end

    // restoring division, msb first
    always_comb begin
        trial = {rem_reg, quo_reg[SW-1]};
        fits  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (ctl.div_start) begin
            quo_reg <= sum_new;
            rem_reg <= '0;
        end else if (ctl.div_step) begin
            quo_reg <= {quo_reg[SW-2:0], fits};
            rem_reg <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
        end
    end

    assign result = (active && !ctl.cnt_zero) ? quo_reg[PW-1:0] : '0;

endmodule

`default_nettype wire

[rtl/lbb_ctrl.sv]
// sequencer: configuration registers, line position, window pointers and count
// depends on lbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbb_ctrl #(
    parameter int MAX_RADIUS = lbb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_LINE   = lbb_pkg::DEF_MAX_LINE,
    parameter int CHANNELS   = lbb_pkg::DEF_CHANNELS
) (
    input  wire                                                   aclk,
    input  wire                                                   aresetn,
    input  wire                                                   cfg_wr_en,
    input  wire  [lbb_pkg::CFG_ADDR_W-1:0]                        cfg_addr,
    input  wire  [lbb_pkg::CFG_DATA_W-1:0]                        cfg_wdata,
    input  wire                                                   s_tvalid,
    output logic                                                  s_tready,
    input  wire                                                   out_free,
    output logic                                                  emit_load,
    output logic                                                  emit_last,
    output lbb_pkg::lane_ctl_t                                    lane_ctl,
    output logic [CHANNELS-1:0]                                   active,
    output logic [$clog2(lbb_pkg::store_depth(MAX_RADIUS))-1:0]   wr_ptr,
    output logic [$clog2(lbb_pkg::store_depth(MAX_RADIUS))-1:0]   drop_ptr,
    output logic [$clog2(lbb_pkg::store_depth(MAX_RADIUS)+1)-1:0] count
);

    localparam int DEPTH = lbb_pkg::store_depth(MAX_RADIUS);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = lbb_pkg::sum_width(MAX_RADIUS);
    localparam int DCW   = $clog2(SW + 1);
    localparam int LW    = lbb_pkg::LINE_W;
    localparam int LXW   = LW + 1;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int NW    = lbb_pkg::CHCNT_W;

    localparam int LEN_LIM_I = (MAX_LINE < (2 ** LW) - 1) ? MAX_LINE : (2 ** LW) - 1;
    localparam logic [LW-1:0]  LEN_LIM  = LW'(LEN_LIM_I);
    localparam logic [LXW-1:0] RAD_LIM  = LXW'(MAX_RADIUS);
    localparam logic [NW-1:0]  CH_LIM   = NW'(CHANNELS);
    localparam logic [AW-1:0]  PTR_LAST = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_FLUSH  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [lbb_pkg::RADIUS_W-1:0] radius_reg;
    logic [LW-1:0]                len_reg;
    logic [NW-1:0]                chcnt_reg;

    logic [LW-1:0]  pos_reg, pos_next;
    logic [LW-1:0]  op_reg, op_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  drop_ptr_reg, drop_ptr_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           last_item_reg, last_item_next;
    logic           flushing_reg, flushing_next;
    logic           emit_last_reg, emit_last_next;

    logic [LW-1:0]  eff_len;
    logic [LXW-1:0] rad_x;
    logic [LXW-1:0] rad_cl;
    logic [LXW-1:0] box_x;
    logic [LXW-1:0] half_len;
    logic [RW-1:0]  eff_re;
    logic [RW:0]    box;
    logic [NW-1:0]  nch;

    logic           s_accept;
    logic           main_drop;
    logic           flush_drop;
    logic           pos_is_last;
    logic [CW-1:0]  count_dec;
    logic [AW-1:0]  wr_ptr_inc;
    logic [AW-1:0]  drop_ptr_inc;
    logic [LW-1:0]  nop;

    // effective line length, radius and channel count
    always_comb begin
        if (len_reg == '0) begin
            eff_len = LW'(1);
        end else if (len_reg > LEN_LIM) begin
            eff_len = LEN_LIM;
        end else begin
            eff_len = len_reg;
        end
        rad_x    = LXW'(radius_reg);
        rad_cl   = (rad_x > RAD_LIM) ? RAD_LIM : rad_x;
        box_x    = {rad_cl[LW-1:0], 1'b1};
        half_len = {2'b00, eff_len[LW-1:1]};
        if ({1'b0, eff_len} < box_x) begin
            eff_re = (half_len != '0) ? RW'(half_len - LXW'(1)) : '0;
        end else begin
            eff_re = RW'(rad_cl);
        end
        box = {eff_re, 1'b1};

        if (chcnt_reg == '0) begin
            nch = NW'(1);
        end else if (chcnt_reg > CH_LIM) begin
            nch = CH_LIM;
        end else begin
            nch = chcnt_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            active[i] = (NW'(i) < nch);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= lbb_pkg::RST_RADIUS;
            len_reg    <= lbb_pkg::RST_LINE_LENGTH;
            chcnt_reg  <= lbb_pkg::RST_CHANNEL_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                lbb_pkg::REG_RADIUS: begin
                    radius_reg <= cfg_wdata[lbb_pkg::RADIUS_W-1:0];
                end
                lbb_pkg::REG_LINE_LENGTH: begin
                    len_reg <= cfg_wdata[LW-1:0];
                end
                lbb_pkg::REG_CHANNEL_COUNT: begin
                    chcnt_reg <= cfg_wdata[NW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign main_drop    = (pos_reg >= LW'(box));
    assign flush_drop   = (op_reg >= LW'(eff_re));
    assign pos_is_last  = (pos_reg == eff_len - LW'(1));
    assign wr_ptr_inc   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
    assign drop_ptr_inc = (drop_ptr_reg == PTR_LAST) ? '0 : drop_ptr_reg + AW'(1);
    assign nop          = flushing_reg ? op_reg + LW'(1) : op_reg;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        wr_ptr_next    = wr_ptr_reg;
        drop_ptr_next  = drop_ptr_reg;
        div_cnt_next   = div_cnt_reg;
        last_item_next = last_item_reg;
        flushing_next  = flushing_reg;
        emit_last_next = emit_last_reg;
        emit_load      = 1'b0;
        count_dec      = count_reg;

        lane_ctl          = '0;
        lane_ctl.wr       = s_accept;
        lane_ctl.div_step = (state_reg == ST_DIVIDE);
        lane_ctl.cnt_zero = (count_reg == '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                lane_ctl.update  = 1'b1;
                lane_ctl.add_pix = 1'b1;
                lane_ctl.drop    = main_drop;
                if (main_drop && count_reg != '0) begin
                    count_dec = count_reg - CW'(1);
                end
                count_next     = count_dec + CW'(1);
                wr_ptr_next    = wr_ptr_inc;
                if (main_drop) begin
                    drop_ptr_next = drop_ptr_inc;
                end
                last_item_next = pos_is_last;
                flushing_next  = 1'b0;
                op_next        = pos_reg - LW'(eff_re);
                if (pos_reg >= LW'(eff_re)) begin
                    lane_ctl.div_start = 1'b1;
                    emit_last_next     = pos_is_last && (eff_re == '0);
                    div_cnt_next       = DCW'(SW);
                    state_next         = ST_DIVIDE;
                end else begin
                    pos_next   = pos_reg + LW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                lane_ctl.update    = flush_drop;
                lane_ctl.drop      = flush_drop;
                lane_ctl.div_start = 1'b1;
                if (flush_drop) begin
                    drop_ptr_next = drop_ptr_inc;
                    if (count_reg != '0) begin
                        count_next = count_reg - CW'(1);
                    end
                end
                emit_last_next = (({1'b0, op_reg} + LXW'(2)) == {1'b0, eff_len});
                div_cnt_next   = DCW'(SW);
                state_next     = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_load = 1'b1;
                    if (!last_item_reg) begin
                        pos_next   = pos_reg + LW'(1);
                        state_next = ST_IDLE;
                    end else if (({1'b0, nop} + LXW'(1)) < {1'b0, eff_len}) begin
                        op_next       = nop;
                        flushing_next = 1'b1;
                        state_next    = ST_FLUSH;
                    end else begin
                        // line done, start over
                        lane_ctl.clear = 1'b1;
                        pos_next       = '0;
                        count_next     = '0;
                        wr_ptr_next    = '0;
                        drop_ptr_next  = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // any configuration write restarts the line
        if (cfg_wr_en) begin
            lane_ctl.clear = 1'b1;
            pos_next       = '0;
            count_next     = '0;
            wr_ptr_next    = '0;
            drop_ptr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            drop_ptr_reg  <= '0;
            div_cnt_reg   <= '0;
            last_item_reg <= 1'b0;
            flushing_reg  <= 1'b0;
            emit_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            wr_ptr_reg    <= wr_ptr_next;
            drop_ptr_reg  <= drop_ptr_next;
            div_cnt_reg   <= div_cnt_next;
            last_item_reg <= last_item_next;
            flushing_reg  <= flushing_next;
            emit_last_reg <= emit_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
    end

    assign emit_last = emit_last_reg;
    assign wr_ptr    = wr_ptr_reg;
    assign drop_ptr  = drop_ptr_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

[rtl/lbb_merge.sv]
// merging stage: packs the lane quotients into one output item register
// depends on lbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbb_merge #(
    parameter int CHANNELS = lbb_pkg::DEF_CHANNELS
) (
    input  wire                                                    aclk,
    input  wire                                                    aresetn,
    input  wire  [CHANNELS-1:0][lbb_pkg::CHAN_W-1:0]               lane_res,
    input  wire                                                    load,
    input  wire                                                    last_in,
    output logic                                                   out_free,
    output logic                                                   m_tvalid,
    input  wire                                                    m_tready,
    output logic [lbb_pkg::NUM_COMP*lbb_pkg::CHAN_W-1:0]           m_tdata,
    output logic                                                   m_tlast
);

    localparam int PW = lbb_pkg::CHAN_W;
    localparam int DW = lbb_pkg::NUM_COMP * PW;

    logic [DW-1:0] packed_next;
    logic [DW-1:0] data_reg;
    logic          last_reg;
    logic          valid_reg;

    // unused components read as zero
    for (genvar i = 0; i < lbb_pkg::NUM_COMP; i++) begin : g_pack
        if (i < CHANNELS) begin : g_used
            assign packed_next[i*PW +: PW] = lane_res[i];
        end else begin : g_zero
            assign packed_next[i*PW +: PW] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= packed_next;
            last_reg <= last_in;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[rtl/line_box_blur_top.sv]
// top level of the line box blur: sequencer, component lanes and merging stage
// depends on lbb_pkg, lbb_ctrl, lbb_lane, lbb_merge
`timescale 1ns / 1ps
`default_nettype none

// Centered one-dimensional box blur along a line of pixels with up to four
// 8-bit components. Every component has its own lane holding a slice of the
// window store, a running sum and a restoring divider; all lanes run in
// lockstep under one sequencer, and a merging register packs their averages
// into the output item. Each output pixel is the truncated mean of the input
// pixels within the effective radius, clipped at both line ends, and output
// lags input by that radius; the last pixel of a line flushes radius+1 items
// with tlast on the final one. Items are taken one at a time: the input stays
// closed until the sequencer is back in idle. An item that yields no output
// passes through the update state only; each output item then runs through the
// divider, one quotient bit per cycle over the SW-bit sum (SW = sum width, 13
// bits at the default MAX_RADIUS), and waits until the output register is free.
// Configuration is to be written only while idle (the block itself does not
// enforce this), and any write, even to an unused index, restarts the line.

module line_box_blur_top #(
    parameter int MAX_RADIUS = lbb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_LINE   = lbb_pkg::DEF_MAX_LINE,
    parameter int CHANNELS   = lbb_pkg::DEF_CHANNELS
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    // configuration write port
    input  wire                                          cfg_wr_en,
    input  wire  [lbb_pkg::CFG_ADDR_W-1:0]               cfg_addr,
    input  wire  [lbb_pkg::CFG_DATA_W-1:0]               cfg_wdata,
    // incoming pixels
    input  wire                                          s_tvalid,
    output logic                                         s_tready,
    // chan_a [7:0], chan_b [15:8], chan_c [23:16], chan_d [31:24]
    input  wire  [lbb_pkg::NUM_COMP*lbb_pkg::CHAN_W-1:0] s_tdata,
    // blurred pixels
    output logic                                         m_tvalid,
    input  wire                                          m_tready,
    // blur_a [7:0], blur_b [15:8], blur_c [23:16], blur_d [31:24]
    output logic [lbb_pkg::NUM_COMP*lbb_pkg::CHAN_W-1:0] m_tdata,
    // line_end: last output item of the line
    output logic                                         m_tlast
);

    localparam int DEPTH = lbb_pkg::store_depth(MAX_RADIUS);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = lbb_pkg::CHAN_W;

    lbb_pkg::lane_ctl_t             lane_ctl;
    logic [CHANNELS-1:0]            active;
    logic [AW-1:0]                  wr_ptr;
    logic [AW-1:0]                  drop_ptr;
    logic [CW-1:0]                  count;
    logic [CHANNELS-1:0][PW-1:0]    lane_res;
    logic                           out_free;
    logic                           emit_load;
    logic                           emit_last;

    // sequencer: config registers, line position, window pointers, divider timing
    lbb_ctrl #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE),
        .CHANNELS   (CHANNELS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .out_free  (out_free),
        .emit_load (emit_load),
        .emit_last (emit_last),
        .lane_ctl  (lane_ctl),
        .active    (active),
        .wr_ptr    (wr_ptr),
        .drop_ptr  (drop_ptr),
        .count     (count)
    );

    // one lane per component; the oldest pixel is read at drop_ptr every cycle
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        lbb_lane #(
            .MAX_RADIUS (MAX_RADIUS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .active  (active[i]),
            .wr_addr (wr_ptr),
            .rd_addr (drop_ptr),
            .divisor (count),
            .pix_in  (s_tdata[i*PW +: PW]),
            .result  (lane_res[i])
        );
    end

    // output register, frees the input side while a result waits
    lbb_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_res (lane_res),
        .load     (emit_load),
        .last_in  (emit_last),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // an accepted item keeps the input closed on the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an item");

    // the window never holds more pixels than the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(DEPTH))
        else $error("window count beyond store depth");

    // a configuration write empties the window and rewinds both pointers
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (count == '0) && (wr_ptr == '0) && (drop_ptr == '0))
        else $error("line not restarted after configuration write");

    // a result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |-> out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire
